### hw/rtl/vmb_pkg.sv
// Shared constants, types and the reciprocal table for the vertical motion blur.
package vmb_pkg;

  localparam int MAX_BLUR = 16;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int BLUR_W   = 5;
  localparam int CNT_W    = $clog2(MAX_BLUR + 1);
  localparam int IDX_W    = (MAX_BLUR > 1) ? $clog2(MAX_BLUR) : 1;
  localparam int CMP_W    = (CNT_W > BLUR_W) ? CNT_W : BLUR_W;
  localparam int SUM_W    = CHAN_W + CNT_W;
  localparam int SHIFT    = SUM_W + CNT_W;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int DIV_N    = 2 ** CNT_W;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic [BLUR_W-1:0] BLUR_RESET = BLUR_W'(4);

  typedef logic [RECIP_W-1:0] recip_tab_t [DIV_N];

  // ceil(2^SHIFT / d) for every nonzero divisor (entry 0 is zero), by shift and subtract. With this
  // rounding, (y * RECIP[d]) >> SHIFT equals floor(y / d) for all y below
  // 2^SUM_W and nonzero d below 2^CNT_W.
  function automatic recip_tab_t build_recip();
    recip_tab_t        tab;
    logic [RECIP_W:0]  num;
    logic [RECIP_W:0]  rem;
    logic [RECIP_W-1:0] quo;
    for (int d = 0; d < DIV_N; d++) begin
      tab[d] = '0;
      if (d != 0) begin
        num = (RECIP_W + 1)'(1) << SHIFT;
        num = num + (RECIP_W + 1)'(d - 1);
        rem = '0;
        quo = '0;
        for (int i = RECIP_W; i >= 0; i--) begin
          rem = {rem[RECIP_W-1:0], num[i]};
          if (rem >= (RECIP_W + 1)'(d)) begin
            rem = rem - (RECIP_W + 1)'(d);
            if (i < RECIP_W) begin
              quo[i] = 1'b1;
            end
          end
        end
        tab[d] = quo;
      end
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MIX,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic mix;
    logic scale;
  } blend_ctrl_t;

endpackage

### hw/rtl/vmb_cell.sv
// One pixel cell of the column window chain.
module vmb_cell import vmb_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [PIX_W-1:0] from_prev,
  input  logic [PIX_W-1:0] from_next,
  output logic [PIX_W-1:0] pix
);

  // A load pushes the chain one place away from the head; a rotate pulls
  // every cell one place toward the head, with the head wrapping to the tail.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pix <= from_prev;
    end else if (ctrl.rotate) begin
      pix <= from_next;
    end
  end

endmodule

### hw/rtl/vmb_blend.sv
// Per-channel accumulator and half-and-half blend with reciprocal divide.
module vmb_blend import vmb_pkg::*; (
  input  logic              clk,
  input  blend_ctrl_t       ctrl,
  input  logic [CHAN_W-1:0] pix_in,
  input  logic [CHAN_W-1:0] head,
  input  logic [CNT_W-1:0]  d,
  output logic [CHAN_W-1:0] cur,
  output logic [CHAN_W-1:0] q
);

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  half;
  logic [SUM_W-1:0]  weighted;
  logic [SUM_W:0]    mix_num;
  logic [PROD_W-1:0] prod;

  assign weighted = SUM_W'(cur) * SUM_W'(d);
  assign mix_num  = (SUM_W + 1)'(sum) + (SUM_W + 1)'(weighted);
  assign prod     = PROD_W'(half) * PROD_W'(RECIP[d]);

  // floor(x / 2d) is taken as floor(floor(x / 2) / d).
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur <= pix_in;
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= sum + SUM_W'(head);
    end
    if (ctrl.mix) begin
      half <= mix_num[SUM_W:1];
    end
    if (ctrl.scale) begin
      q <= prod[SHIFT +: CHAN_W];
    end
  end

endmodule

### hw/rtl/vertical_motion_blur_top.sv
// Vertical motion blur: pixel window chain, control sequencer and output register.
// A pixel steps through ST_SUM, ST_MIX, ST_SCALE and ST_DONE, which waits while a
// valid output is stalled; no new pixel is taken until the result is loaded. The window
// chain makes one full rotation per pixel to feed the channel sums.
// Reset clears the sequencer, the pixel count and out_valid and sets blur_amount
// to 4; window cells are not cleared, as only pixels of the current column are used.
module vertical_motion_blur_top import vmb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [BLUR_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] pixel_red,
  input  logic [CHAN_W-1:0] pixel_green,
  input  logic [CHAN_W-1:0] pixel_blue,
  input  logic              column_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue
);

  state_t            state;
  state_t            state_next;
  logic [BLUR_W-1:0] blur_amount;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n_reg;
  logic [CNT_W-1:0]  d_reg;
  logic [IDX_W-1:0]  step;

  logic              in_take;
  logic              out_load;
  logic              last_step;
  logic [CMP_W-1:0]  blur_ext;
  logic [CNT_W-1:0]  blur_sat;
  logic [CNT_W-1:0]  count_base;
  logic [CNT_W-1:0]  n_sel;
  logic [CNT_W-1:0]  d_sel;
  logic [CNT_W-1:0]  count_inc;

  cell_ctrl_t        cell_ctrl;
  blend_ctrl_t       blend_ctrl;
  logic [PIX_W-1:0]  cell_pix [MAX_BLUR];
  logic [PIX_W-1:0]  cur_pix;
  logic [PIX_W-1:0]  head_pix;
  logic [CHAN_W-1:0] cur_r, cur_g, cur_b;
  logic [CHAN_W-1:0] q_r, q_g, q_b;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Window size for this pixel: blur amount, capped, limited to pixels held.
  assign blur_ext   = CMP_W'(blur_amount);
  assign blur_sat   = (blur_ext > CMP_W'(MAX_BLUR)) ? CNT_W'(MAX_BLUR) : CNT_W'(blur_ext);
  assign count_base = column_start ? '0 : count;
  assign n_sel      = (blur_sat < count_base) ? blur_sat : count_base;
  assign d_sel      = (n_sel == '0) ? CNT_W'(1) : n_sel;
  assign count_inc  = (count_base == CNT_W'(MAX_BLUR)) ? count_base : count_base + 1'b1;
  assign last_step  = (step == IDX_W'(MAX_BLUR - 1));

  always_comb begin
    state_next       = state;
    cell_ctrl        = '0;
    blend_ctrl       = '0;
    out_load         = 1'b0;
    case (state)
      ST_IDLE: begin
        blend_ctrl.load = in_take;
        if (in_take) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cell_ctrl.rotate = 1'b1;
        blend_ctrl.acc   = (CNT_W'(step) < n_reg);
        if (last_step) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        // The chain is back in order; the current pixel now enters it.
        cell_ctrl.load = 1'b1;
        blend_ctrl.mix = 1'b1;
        state_next     = ST_SCALE;
      end
      ST_SCALE: begin
        blend_ctrl.scale = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_amount <= BLUR_RESET;
      count       <= '0;
      step        <= '0;
      n_reg       <= '0;
      d_reg       <= CNT_W'(1);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blur_amount <= cfg_wr_data;
      end
      if (in_take) begin
        n_reg <= n_sel;
        d_reg <= d_sel;
        count <= count_inc;
        step  <= '0;
      end else if (state == ST_SUM) begin
        step <= step + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red   <= q_r;
      out_green <= q_g;
      out_blue  <= q_b;
    end
  end

  assign cur_pix  = {cur_r, cur_g, cur_b};
  assign head_pix = cell_pix[0];

  for (genvar k = 0; k < MAX_BLUR; k++) begin : g_cell
    logic [PIX_W-1:0] prev_pix;
    logic [PIX_W-1:0] next_pix;
    if (k == 0) begin : g_head
      assign prev_pix = cur_pix;
    end else begin : g_body
      assign prev_pix = cell_pix[k-1];
    end
    if (k == MAX_BLUR - 1) begin : g_tail
      assign next_pix = cell_pix[0];
    end else begin : g_inner
      assign next_pix = cell_pix[k+1];
    end
    vmb_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .from_prev (prev_pix),
      .from_next (next_pix),
      .pix       (cell_pix[k])
    );
  end

  vmb_blend u_blend_r (
    .clk    (clk),
    .ctrl   (blend_ctrl),
    .pix_in (pixel_red),
    .head   (head_pix[2*CHAN_W +: CHAN_W]),
    .d      (d_reg),
    .cur    (cur_r),
    .q      (q_r)
  );

  vmb_blend u_blend_g (
    .clk    (clk),
    .ctrl   (blend_ctrl),
    .pix_in (pixel_green),
    .head   (head_pix[CHAN_W +: CHAN_W]),
    .d      (d_reg),
    .cur    (cur_g),
    .q      (q_g)
  );

  vmb_blend u_blend_b (
    .clk    (clk),
    .ctrl   (blend_ctrl),
    .pix_in (pixel_blue),
    .head   (head_pix[0 +: CHAN_W]),
    .d      (d_reg),
    .cur    (cur_b),
    .q      (q_b)
  );

  a_take_starts_sum: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_SUM))
    else $error("accepted transaction did not start the window sum");

  a_mix_after_full_rotation: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX) |-> ($past(state) == ST_SUM && $past(step) == IDX_W'(MAX_BLUR - 1)))
    else $error("window chain loaded before a full rotation");

  a_window_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (n_reg <= count && d_reg != '0 && d_reg <= CNT_W'(MAX_BLUR)))
    else $error("window size out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result presented without a finished computation");

endmodule
